FILE: rtl/bdeq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
// Used by bdeq_ctrl and bounded_double_ended_queue; no dependencies.
package bdeq_pkg;

	// Request codes; codes 6 and 7 are accepted and dropped.
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_LIST       = 3'd4;
	localparam logic [2:0] REQ_CREATE     = 3'd5;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_OVERFLOW   = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW  = 2'd2;
	localparam logic [1:0] ST_LIST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] item_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_out;
		logic               last;
	} res_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_LIST
	} state_t;

endpackage

FILE: rtl/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: entry store plus controller.
// Depends on bdeq_pkg and bdeq_ctrl.

// A request is taken when start is high and busy is low. Push, create and the
// unused codes leave busy low and may follow back to back; a pop that finds an
// entry passes through S_POP because the entry store has a registered read,
// and a pop from an empty store does not; a list of entries passes through
// S_LIST, streaming one entry per cycle from the store's single read port, and
// an empty list does not. Each result sits on res for exactly one cycle with
// res_valid high, starting the cycle after its data is read or the request is
// taken; the receiver cannot stall it, so sample every cycle that res_valid is
// high. res.last marks the final result of a request.
// No reset sweep: the store is never read outside the live range.
module bounded_double_ended_queue #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bdeq_pkg::req_t req,
	output logic           res_valid,
	output bdeq_pkg::res_t res
);

	localparam int IDX_W = $clog2(CAPACITY);

	bdeq_pkg::mem_ctl_t mem_ctl;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic signed [31:0] wr_data;
	logic signed [31:0] rd_data_q;
	logic signed [31:0] store_q [CAPACITY];

	bdeq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.res_valid(res_valid),
		.res      (res),
		.mem_ctl  (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data_q)
	);

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en)
			store_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en)
			rd_data_q <= store_q[rd_addr];
	end

endmodule

FILE: rtl/bdeq_ctrl.sv
// Queue controller: front/count pointers, request decode and the result register.
// Drives the entry store in the top level; depends on bdeq_pkg.
module bdeq_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  bdeq_pkg::req_t           req,
	output logic                     res_valid,
	output bdeq_pkg::res_t           res,
	output bdeq_pkg::mem_ctl_t       mem_ctl,
	output logic [$clog2(CAPACITY)-1:0] wr_addr,
	output logic signed [31:0]       wr_data,
	output logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic signed [31:0]       rd_data
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = IDX_W + 1;

	bdeq_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] off_q;
	bdeq_pkg::res_t   res_q;
	logic             res_valid_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic             list_last;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] back_slot;
	logic [IDX_W-1:0] tail_slot;
	logic [IDX_W-1:0] list_slot;

	// Offsets never reach twice the capacity, so one subtract folds the sum.
	function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(CAPACITY)) ? (s - SUM_W'(CAPACITY)) : s;
		return r[IDX_W-1:0];
	endfunction

	assign accept    = start && (state_q == bdeq_pkg::S_IDLE);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign list_last = (off_q == (count_q - CNT_W'(1)));
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : (front_q - IDX_W'(1));
	assign front_inc = wrap(SUM_W'(front_q) + SUM_W'(1));
	assign back_slot = wrap(SUM_W'(front_q) + SUM_W'(count_q));
	assign tail_slot = wrap(SUM_W'(front_q) + SUM_W'(count_q) - SUM_W'(1));
	assign list_slot = wrap(SUM_W'(front_q) + SUM_W'(off_q) + SUM_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdeq_pkg::S_IDLE: begin
				if (accept) begin
					if ((req.req_type == bdeq_pkg::REQ_POP_FRONT ||
					     req.req_type == bdeq_pkg::REQ_POP_BACK) && !empty)
						state_d = bdeq_pkg::S_POP;
					else if (req.req_type == bdeq_pkg::REQ_LIST && !empty)
						state_d = bdeq_pkg::S_LIST;
				end
			end
			bdeq_pkg::S_POP: state_d = bdeq_pkg::S_IDLE;
			bdeq_pkg::S_LIST: begin
				if (list_last)
					state_d = bdeq_pkg::S_IDLE;
			end
			default: state_d = bdeq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_ctl = '0;
		wr_addr = front_dec;
		rd_addr = front_q;
		wr_data = req.item_in;
		unique case (state_q)
			bdeq_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						bdeq_pkg::REQ_PUSH_FRONT: begin
							mem_ctl.wr_en = !full;
							wr_addr       = front_dec;
						end
						bdeq_pkg::REQ_PUSH_BACK: begin
							mem_ctl.wr_en = !full;
							wr_addr       = back_slot;
						end
						bdeq_pkg::REQ_POP_FRONT: begin
							mem_ctl.rd_en = !empty;
							rd_addr       = front_q;
						end
						bdeq_pkg::REQ_POP_BACK: begin
							mem_ctl.rd_en = !empty;
							rd_addr       = tail_slot;
						end
						bdeq_pkg::REQ_LIST: begin
							mem_ctl.rd_en = !empty;
							rd_addr       = front_q;
						end
						bdeq_pkg::REQ_CREATE: begin
							mem_ctl.wr_en = 1'b1;
							wr_addr       = '0;
						end
						default: ;
					endcase
				end
			end
			bdeq_pkg::S_LIST: begin
				// prefetch the next entry while the current one goes out
				mem_ctl.rd_en = !list_last;
				rd_addr       = list_slot;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdeq_pkg::S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			off_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= 1'b0;
			unique case (state_q)
				bdeq_pkg::S_IDLE: begin
					if (accept) begin
						unique case (req.req_type)
							bdeq_pkg::REQ_PUSH_FRONT: begin
								res_valid_q <= 1'b1;
								if (!full) begin
									front_q <= front_dec;
									count_q <= count_q + CNT_W'(1);
								end
							end
							bdeq_pkg::REQ_PUSH_BACK: begin
								res_valid_q <= 1'b1;
								if (!full)
									count_q <= count_q + CNT_W'(1);
							end
							bdeq_pkg::REQ_POP_FRONT: begin
								if (empty) begin
									res_valid_q <= 1'b1;
								end else begin
									front_q <= front_inc;
									count_q <= count_q - CNT_W'(1);
								end
							end
							bdeq_pkg::REQ_POP_BACK: begin
								if (empty)
									res_valid_q <= 1'b1;
								else
									count_q <= count_q - CNT_W'(1);
							end
							bdeq_pkg::REQ_LIST: begin
								off_q <= '0;
								if (empty)
									res_valid_q <= 1'b1;
							end
							bdeq_pkg::REQ_CREATE: begin
								res_valid_q <= 1'b1;
								front_q     <= '0;
								count_q     <= CNT_W'(1);
							end
							default: ;
						endcase
					end
				end
				bdeq_pkg::S_POP: res_valid_q <= 1'b1;
				bdeq_pkg::S_LIST: begin
					res_valid_q <= 1'b1;
					off_q       <= off_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Result payload, no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bdeq_pkg::S_IDLE: begin
				res_q.item_out <= '0;
				res_q.last     <= 1'b1;
				priority if ((req.req_type == bdeq_pkg::REQ_PUSH_FRONT ||
				              req.req_type == bdeq_pkg::REQ_PUSH_BACK) && full)
					res_q.status <= bdeq_pkg::ST_OVERFLOW;
				else if ((req.req_type == bdeq_pkg::REQ_POP_FRONT ||
				          req.req_type == bdeq_pkg::REQ_POP_BACK) && empty)
					res_q.status <= bdeq_pkg::ST_UNDERFLOW;
				else if (req.req_type == bdeq_pkg::REQ_LIST && empty)
					res_q.status <= bdeq_pkg::ST_LIST_EMPTY;
				else
					res_q.status <= bdeq_pkg::ST_OK;
			end
			bdeq_pkg::S_POP: begin
				res_q.status   <= bdeq_pkg::ST_OK;
				res_q.item_out <= rd_data;
				res_q.last     <= 1'b1;
			end
			bdeq_pkg::S_LIST: begin
				res_q.status   <= bdeq_pkg::ST_OK;
				res_q.item_out <= rd_data;
				res_q.last     <= list_last;
			end
			default: res_q <= '0;
		endcase
	end

	assign busy      = (state_q != bdeq_pkg::S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
